[sv/pfe_pkg.sv]
`default_nettype none
package pfe_pkg;

    localparam int TABLE_SIDE = 5;
    localparam int CELLS      = TABLE_SIDE * TABLE_SIDE;
    localparam int ALPHABET   = 26;

    localparam int LETTER_W = 5;
    localparam int CELL_W   = $clog2(CELLS);
    localparam int ROW_W    = $clog2(TABLE_SIDE);
    localparam int REQ_W    = 2;

    localparam logic [LETTER_W-1:0] FILLER_RESET  = LETTER_W'(23);
    localparam logic [LETTER_W-1:0] OMITTED_RESET = LETTER_W'(16);

    localparam logic REG_FILLER  = 1'b0;
    localparam logic REG_OMITTED = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        KIND_KEY    = 2'd0,
        KIND_FINISH = 2'd1,
        KIND_TEXT   = 2'd2,
        KIND_END    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [LETTER_W-1:0] letter;
    } t_qitem;

    typedef struct packed {
        logic   valid;
        t_qitem item;
    } t_qhead;

    typedef struct packed {
        logic [LETTER_W-1:0] filler;
        logic [LETTER_W-1:0] omitted;
    } t_cfg;

    function automatic logic [ROW_W-1:0] pos_row(input logic [CELL_W-1:0] p);
        logic [ROW_W-1:0] r;
        r = '0;
        for (int k = 1; k < TABLE_SIDE; k++) begin
            if (p >= CELL_W'(k * TABLE_SIDE)) begin
                r = ROW_W'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] pos_col(input logic [CELL_W-1:0] p,
                                                 input logic [ROW_W-1:0]  r);
        logic [CELL_W-1:0] base;
        base = CELL_W'(r) * CELL_W'(TABLE_SIDE);
        return ROW_W'(p - base);
    endfunction

    function automatic logic [ROW_W-1:0] wrap_next(input logic [ROW_W-1:0] c);
        return (c == ROW_W'(TABLE_SIDE - 1)) ? '0 : ROW_W'(c + 1'b1);
    endfunction

    function automatic logic [CELL_W-1:0] pos_cell(input logic [ROW_W-1:0] r,
                                                   input logic [ROW_W-1:0] c);
        return CELL_W'(r) * CELL_W'(TABLE_SIDE) + CELL_W'(c);
    endfunction

endpackage
`default_nettype wire

[sv/pfe_in_if.sv]
`default_nettype none
interface pfe_in_if;
    logic                          valid;
    logic                          ready;
    logic [pfe_pkg::REQ_W-1:0]     req_type;
    logic [pfe_pkg::LETTER_W-1:0]  letter;

    modport source (output valid, output req_type, output letter, input ready);
    modport sink   (input valid, input req_type, input letter, output ready);
endinterface
`default_nettype wire

[sv/pfe_out_if.sv]
`default_nettype none
interface pfe_out_if;
    logic                          valid;
    logic                          ready;
    logic [pfe_pkg::LETTER_W-1:0]  cipher_letter;
    logic                          pair_end;

    modport source (output valid, output cipher_letter, output pair_end, input ready);
    modport sink   (input valid, input cipher_letter, input pair_end, output ready);
endinterface
`default_nettype wire

[sv/pfe_front.sv]
`default_nettype none
module pfe_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    pfe_in_if.sink                i_in,
    input  wire logic             i_pop,
    output pfe_pkg::t_qhead       o_head
);

    localparam int DEPTH = 2;

    pfe_pkg::t_qitem r_q [DEPTH];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;

    pfe_pkg::t_qitem s_item;
    logic            s_keep;
    logic            s_push;

    assign i_in.ready = (r_count != 2'(DEPTH));

    always_comb begin
        s_item.kind   = pfe_pkg::t_kind'(i_in.req_type);
        s_item.letter = i_in.letter;
        // drop key and text letters outside the alphabet
        unique case (s_item.kind) inside
            pfe_pkg::KIND_KEY, pfe_pkg::KIND_TEXT:
                s_keep = (i_in.letter < pfe_pkg::LETTER_W'(pfe_pkg::ALPHABET));
            default: s_keep = 1'b1;
        endcase
    end

    assign s_push = i_in.valid && i_in.ready && s_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (s_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(s_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_q[r_wr_ptr] <= s_item;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_q[r_rd_ptr];

endmodule
`default_nettype wire

[sv/pfe_back.sv]
`default_nettype none
module pfe_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pfe_pkg::t_qhead  i_head,
    output logic                  o_pop,
    input  wire pfe_pkg::t_cfg    i_cfg,
    pfe_out_if.source             o_out
);

    localparam int LW = pfe_pkg::LETTER_W;
    localparam int CW = pfe_pkg::CELL_W;
    localparam int RW = pfe_pkg::ROW_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_CALC,
        ST_EMIT0,
        ST_EMIT1
    } t_state;

    t_state                      r_state;
    logic                        r_key_ready;
    logic [CW-1:0]               r_fill;
    logic [pfe_pkg::ALPHABET-1:0] r_used;
    logic [LW-1:0]               r_sweep;
    logic [LW-1:0]               r_pending;
    logic                        r_pending_valid;
    logic                        r_ua;
    logic                        r_ub;
    logic                        r_out_valid;
    logic [LW-1:0]               r_out_letter;
    logic                        r_out_pair_end;

    logic [LW-1:0] mem_key_table [pfe_pkg::CELLS];
    logic [CW-1:0] mem_position  [pfe_pkg::ALPHABET];
    logic [CW-1:0] r_pos_a;
    logic [CW-1:0] r_pos_b;
    logic [LW-1:0] r_ka;
    logic [LW-1:0] r_kb;

    logic          s_place;
    logic [LW-1:0] s_place_letter;
    logic          s_place_ok;
    logic          s_start;
    logic [LW-1:0] s_b;
    logic [LW-1:0] s_addr_b;
    logic          s_head_used;
    logic          s_b_used;
    logic          s_load;

    logic [CW-1:0] s_pa, s_pb, s_oa, s_ob;
    logic [RW-1:0] s_ra, s_ca, s_rb, s_cb;

    function automatic logic letter_used(input logic [LW-1:0] x,
                                         input logic [pfe_pkg::ALPHABET-1:0] used);
        return (x < LW'(pfe_pkg::ALPHABET)) && used[x];
    endfunction

    assign s_head_used = letter_used(i_head.item.letter, r_used);
    assign s_b_used    = letter_used(s_b, r_used);

    always_comb begin
        o_pop          = 1'b0;
        s_place        = 1'b0;
        s_place_letter = i_head.item.letter;
        s_start        = 1'b0;
        s_b            = i_cfg.filler;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    unique case (i_head.item.kind)
                        pfe_pkg::KIND_KEY: begin
                            s_place = !r_key_ready;
                        end
                        pfe_pkg::KIND_FINISH: begin
                        end
                        pfe_pkg::KIND_TEXT: begin
                            s_start = r_key_ready && s_head_used && r_pending_valid;
                            if (r_pending != i_head.item.letter) begin
                                s_b = i_head.item.letter;
                            end
                        end
                        pfe_pkg::KIND_END: begin
                            s_start = r_key_ready && r_pending_valid;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                s_place        = 1'b1;
                s_place_letter = r_sweep;
            end
            default: begin
            end
        endcase
    end

    assign s_place_ok = s_place && (r_fill < CW'(pfe_pkg::CELLS))
                     && (s_place_letter != i_cfg.omitted) && !r_used[s_place_letter];

    assign s_addr_b = (s_b < LW'(pfe_pkg::ALPHABET)) ? s_b : '0;

    // pair encryption on the two looked-up positions
    always_comb begin
        s_pa = r_ua ? r_pos_a : '0;
        s_pb = r_ub ? r_pos_b : '0;
        s_ra = pfe_pkg::pos_row(s_pa);
        s_rb = pfe_pkg::pos_row(s_pb);
        s_ca = pfe_pkg::pos_col(s_pa, s_ra);
        s_cb = pfe_pkg::pos_col(s_pb, s_rb);
        if (s_ra == s_rb) begin
            s_oa = pfe_pkg::pos_cell(s_ra, pfe_pkg::wrap_next(s_ca));
            s_ob = pfe_pkg::pos_cell(s_rb, pfe_pkg::wrap_next(s_cb));
        end else if (s_ca == s_cb) begin
            s_oa = pfe_pkg::pos_cell(pfe_pkg::wrap_next(s_ra), s_ca);
            s_ob = pfe_pkg::pos_cell(pfe_pkg::wrap_next(s_rb), s_cb);
        end else begin
            s_oa = pfe_pkg::pos_cell(s_ra, s_cb);
            s_ob = pfe_pkg::pos_cell(s_rb, s_ca);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_place_ok) begin
            mem_key_table[r_fill]        <= s_place_letter;
            mem_position[s_place_letter] <= r_fill;
        end
        if (s_start) begin
            r_pos_a <= mem_position[r_pending];
            r_pos_b <= mem_position[s_addr_b];
        end
        if (r_state == ST_CALC) begin
            r_ka <= mem_key_table[s_oa];
            r_kb <= mem_key_table[s_ob];
        end
    end

    assign s_load = (!r_out_valid || o_out.ready)
                 && ((r_state == ST_EMIT0) || (r_state == ST_EMIT1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_key_ready     <= 1'b0;
            r_fill          <= '0;
            r_used          <= '0;
            r_sweep         <= '0;
            r_pending       <= '0;
            r_pending_valid <= 1'b0;
            r_ua            <= 1'b0;
            r_ub            <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (s_place_ok) begin
                r_used[s_place_letter] <= 1'b1;
                r_fill                 <= r_fill + 1'b1;
            end

            if (s_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_head.valid) begin
                        unique case (i_head.item.kind)
                            pfe_pkg::KIND_FINISH: begin
                                if (!r_key_ready) begin
                                    r_sweep <= '0;
                                    r_state <= ST_FILL;
                                end
                            end
                            pfe_pkg::KIND_TEXT: begin
                                if (r_key_ready && s_head_used) begin
                                    if (!r_pending_valid) begin
                                        r_pending       <= i_head.item.letter;
                                        r_pending_valid <= 1'b1;
                                    end else if (r_pending != i_head.item.letter) begin
                                        r_pending_valid <= 1'b0;
                                    end
                                end
                            end
                            pfe_pkg::KIND_END: begin
                                if (s_start) begin
                                    r_pending_valid <= 1'b0;
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (s_start) begin
                            r_ua    <= 1'b1;
                            r_ub    <= s_b_used;
                            r_state <= ST_CALC;
                        end
                    end
                end
                ST_FILL: begin
                    if (r_sweep == LW'(pfe_pkg::ALPHABET - 1)) begin
                        r_key_ready <= 1'b1;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_sweep <= r_sweep + 1'b1;
                    end
                end
                ST_CALC: begin
                    r_state <= ST_EMIT0;
                end
                ST_EMIT0: begin
                    if (s_load) begin
                        r_out_letter   <= r_ka;
                        r_out_pair_end <= 1'b0;
                        r_state        <= ST_EMIT1;
                    end
                end
                ST_EMIT1: begin
                    if (s_load) begin
                        r_out_letter   <= r_kb;
                        r_out_pair_end <= 1'b1;
                        r_state        <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.cipher_letter = r_out_letter;
    assign o_out.pair_end      = r_out_pair_end;

endmodule
`default_nettype wire

[sv/playfair_digraph_encryptor.sv]
// Path: a closing plaintext letter or end beat goes through the front queue, the
// position lookup, the key table lookup (ST_CALC) and the output register (ST_EMIT0);
// the second cipher beat follows from ST_EMIT1. Finish key runs an alphabet sweep.
// While a pair is encrypted the back end pops nothing; the two-entry queue still fills.
// Reset (synchronous, active low): table empty, key not finished, no waiting letter,
// queue empty, filler x and omitted q; no clearing pass.
`default_nettype none
module playfair_digraph_encryptor (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    pfe_in_if.sink             i_in,
    pfe_out_if.source          o_out,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int LW = pfe_pkg::LETTER_W;

    logic [LW-1:0]   r_filler;
    logic [LW-1:0]   r_omitted;
    pfe_pkg::t_cfg   s_cfg;
    pfe_pkg::t_qhead s_head;
    logic            s_pop;
    logic            s_wr;

    assign pready = 1'b1;
    assign s_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filler  <= pfe_pkg::FILLER_RESET;
            r_omitted <= pfe_pkg::OMITTED_RESET;
        end else if (s_wr) begin
            case (paddr[2])
                pfe_pkg::REG_FILLER:  r_filler  <= pwdata[LW-1:0];
                pfe_pkg::REG_OMITTED: r_omitted <= pwdata[LW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            pfe_pkg::REG_FILLER:  prdata = {{(32-LW){1'b0}}, r_filler};
            pfe_pkg::REG_OMITTED: prdata = {{(32-LW){1'b0}}, r_omitted};
            default:              prdata = '0;
        endcase
    end

    assign s_cfg.filler  = r_filler;
    assign s_cfg.omitted = r_omitted;

    pfe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (s_pop),
        .o_head  (s_head)
    );

    pfe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (s_head),
        .o_pop   (s_pop),
        .i_cfg   (s_cfg),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire
